@@ rtl/core/srs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srs_pkg: shared types and constants for segment rule substitution
// Coordinate formats, register indexes, flip codes and the payload
// structs that travel between the sequencer, the point mapper and the ports.
// ---------------------------------------------------------------------------
package srs_pkg;

  // Coordinates are signed Q16.16
  localparam int COORD_W         = 32;
  localparam int MAX_RULE_POINTS = 7;

  // Rule points are signed Q2.14, packed x high, y low
  localparam int RULE_W    = 16;
  localparam int FRAC_W    = 14;
  localparam int ONE_Q14   = 1 << FRAC_W;
  // A flipped rule coordinate needs one bit more than the stored one
  localparam int RX_W      = RULE_W + 1;
  // Segment deltas need one bit more than a coordinate
  localparam int DX_W      = COORD_W + 1;

  // Configuration port
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 2 * RULE_W;
  localparam int NUM_REGS   = 1 + MAX_RULE_POINTS;
  localparam int REG_RULE_COUNT   = 0;
  localparam int REG_RULE_POINT_0 = 1;

  // Point position within one segment: start, rule points, end
  localparam int POS_W = $clog2(MAX_RULE_POINTS + 3);
  localparam int IDX_W = (MAX_RULE_POINTS > 1) ? $clog2(MAX_RULE_POINTS) : 1;

  // Random flip source
  localparam int             LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // Flip mode codes
  localparam logic [2:0] FLIP_NONE = 3'd0;
  localparam logic [2:0] FLIP_V    = 3'd1;
  localparam logic [2:0] FLIP_H    = 3'd2;
  localparam logic [2:0] FLIP_BOTH = 3'd3;
  localparam logic [2:0] FLIP_RAND = 3'd4;

  // One input segment
  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [2:0]                flip_mode;
    logic                      first_segment;
  } seg_t;

  // One emitted point
  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      last_point;
  } pt_t;

  // Request from the sequencer to the point mapper
  typedef struct packed {
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
    logic signed [DX_W-1:0]    dx;
    logic signed [DX_W-1:0]    dy;
    logic signed [RX_W-1:0]    rx;
    logic signed [RX_W-1:0]    ry;
    logic                      mapped;
    logic                      last;
  } map_req_t;

endpackage
`default_nettype wire

@@ rtl/core/srs_point_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srs_point_map: affine map of one rule point onto a segment
// Stage one registers the four cross products, stage two rounds, adds the
// base coordinate and saturates into the output register.
// ---------------------------------------------------------------------------
module srs_point_map (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  srs_pkg::map_req_t req,
  output logic             pt_valid,
  input  logic             pt_ready,
  output srs_pkg::pt_t     pt
);
  import srs_pkg::*;

  localparam int PROD_W = RX_W + DX_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - FRAC_W;
  localparam int TOT_W  = RND_W + 1;

  // Clamp a wide signed value into the coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [TOT_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v[TOT_W-1:COORD_W-1] == '0 || v[TOT_W-1:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[TOT_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Product stage registers
  logic                      p_valid;
  logic signed [PROD_W-1:0]  p_xdx, p_ydy, p_xdy, p_ydx;
  logic signed [COORD_W-1:0] p_base_x, p_base_y;
  logic                      p_mapped, p_last;

  logic o_free, p_free;

  assign o_free    = !pt_valid || pt_ready;
  assign p_free    = !p_valid || o_free;
  assign req_ready = p_free;

  // Advance valid bits through the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      pt_valid <= 1'b0;
    end else begin
      if (p_free) p_valid <= req_valid;
      if (o_free) pt_valid <= p_valid;
    end
  end

  // Capture products of the rule point and the segment deltas
  always_ff @(posedge clk) begin
    if (p_free && req_valid) begin
      p_xdx    <= req.rx * req.dx;
      p_ydy    <= req.ry * req.dy;
      p_xdy    <= req.rx * req.dy;
      p_ydx    <= req.ry * req.dx;
      p_base_x <= req.base_x;
      p_base_y <= req.base_y;
      p_mapped <= req.mapped;
      p_last   <= req.last;
    end
  end

  // Round half up to Q16.16, add the base and saturate
  logic signed [SUM_W-1:0] sum_x, sum_y, rsum_x, rsum_y;
  logic signed [RND_W-1:0] rnd_x, rnd_y;
  logic signed [TOT_W-1:0] tot_x, tot_y;

  always_comb begin
    sum_x  = SUM_W'(p_xdx) - SUM_W'(p_ydy);
    sum_y  = SUM_W'(p_xdy) + SUM_W'(p_ydx);
    rsum_x = sum_x + SUM_W'(ONE_Q14 / 2);
    rsum_y = sum_y + SUM_W'(ONE_Q14 / 2);
    rnd_x  = $signed(rsum_x[SUM_W-1:FRAC_W]);
    rnd_y  = $signed(rsum_y[SUM_W-1:FRAC_W]);
    tot_x  = TOT_W'(p_base_x) + (p_mapped ? TOT_W'(rnd_x) : TOT_W'(0));
    tot_y  = TOT_W'(p_base_y) + (p_mapped ? TOT_W'(rnd_y) : TOT_W'(0));
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (o_free && p_valid) begin
      pt.out_x      <= sat_coord(tot_x);
      pt.out_y      <= sat_coord(tot_y);
      pt.last_point <= p_last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/segment_rule_substitution.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// segment_rule_substitution: replace one segment by mapped rule points
// Takes a segment and a flip mode, emits the optional start point, the
// rule points mapped onto the segment, and the end point.
// ---------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  seg      in         seg_valid / seg_ready  srs_pkg::seg_t
//  pt       out        pt_valid  / pt_ready   srs_pkg::pt_t
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One segment yields first_segment + rule_count + 1 points, one per cycle
// while pt_ready holds, from the single point sequencer feeding one mapping
// pipe. The next segment is taken in the cycle its predecessor's end point
// leaves the sequencer.
// After the segment transfer its first point passes the sequencer, product and output registers.
// Synchronous reset empties all stages and loads the LFSR seed.
// A stalled pt channel backs up through the pipe to seg_ready.
// ---------------------------------------------------------------------------
module segment_rule_substitution (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          seg_valid,
  output logic                          seg_ready,
  input  srs_pkg::seg_t                 seg,
  output logic                          pt_valid,
  input  logic                          pt_ready,
  output srs_pkg::pt_t                  pt,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srs_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0]      rule_count;
  logic [CFG_DATA_W-1:0] rule_pts [MAX_RULE_POINTS];
  logic [LFSR_W-1:0]     lfsr;

  // Segment held by the sequencer
  logic                      busy;
  logic [POS_W-1:0]          pos;
  logic signed [COORD_W-1:0] sx, sy, ex, ey;
  logic signed [DX_W-1:0]    dx, dy;
  logic                      vflip, hflip, first;
  logic [CNT_W-1:0]          cnt;

  logic     req_ready;
  map_req_t req;

  assign cfg_ready = 1'b1;

  // Write configuration registers; out-of-list indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
      for (int i = 0; i < MAX_RULE_POINTS; i++) begin
        rule_pts[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_W'(REG_RULE_COUNT)) begin
        rule_count <= cfg_data[CNT_W-1:0];
      end else if (cfg_index >= CFG_IDX_W'(REG_RULE_POINT_0) &&
                   cfg_index < CFG_IDX_W'(NUM_REGS)) begin
        rule_pts[IDX_W'(cfg_index - CFG_IDX_W'(REG_RULE_POINT_0))] <= cfg_data;
      end
    end
  end

  // Decode flip mode and step the LFSR for random mode
  logic              lfsr_fb;
  logic [LFSR_W-1:0] lfsr_next;
  logic              vflip_next, hflip_next, lfsr_step;
  logic [CNT_W-1:0]  cnt_next;

  always_comb begin
    lfsr_fb    = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
    lfsr_next  = {lfsr_fb, lfsr[LFSR_W-1:1]};
    vflip_next = 1'b0;
    hflip_next = 1'b0;
    lfsr_step  = 1'b0;
    case (seg.flip_mode)
      FLIP_V: begin
        vflip_next = 1'b1;
      end
      FLIP_H: begin
        hflip_next = 1'b1;
      end
      FLIP_BOTH: begin
        vflip_next = 1'b1;
        hflip_next = 1'b1;
      end
      FLIP_RAND: begin
        lfsr_step  = 1'b1;
        vflip_next = lfsr_next[0];
      end
      default: begin
        vflip_next = 1'b0;
      end
    endcase
    cnt_next = (rule_count > CNT_W'(MAX_RULE_POINTS)) ? CNT_W'(MAX_RULE_POINTS)
                                                      : rule_count;
  end

  // Pick the point at the current position
  logic [POS_W-1:0]      k, ridx;
  logic                  is_start, is_end;
  logic [IDX_W-1:0]      idx;
  logic [CFG_DATA_W-1:0] w;
  logic signed [RX_W-1:0] rx0, ry0;
  logic                  emit, seg_xfer;

  always_comb begin
    is_start = first && (pos == '0);
    k        = pos - POS_W'(first);
    is_end   = !is_start && (k == POS_W'(cnt));
    ridx     = hflip ? (POS_W'(cnt) - POS_W'(1) - k) : k;
    idx      = ridx[IDX_W-1:0];
    w        = (ridx < POS_W'(MAX_RULE_POINTS)) ? rule_pts[idx] : '0;
    rx0      = RX_W'($signed(w[CFG_DATA_W-1:RULE_W]));
    ry0      = RX_W'($signed(w[RULE_W-1:0]));

    req.base_x = is_end ? ex : sx;
    req.base_y = is_end ? ey : sy;
    req.dx     = dx;
    req.dy     = dy;
    req.rx     = hflip ? (RX_W'(ONE_Q14) - rx0) : rx0;
    req.ry     = vflip ? -ry0 : ry0;
    req.mapped = !is_start && !is_end;
    req.last   = is_end;
  end

  assign emit      = busy && req_ready;
  assign seg_ready = !busy || (emit && is_end);
  assign seg_xfer  = seg_valid && seg_ready;

  // Sequencer control: load a segment, advance one point per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
      lfsr <= LFSR_SEED;
    end else begin
      if (seg_xfer) begin
        busy <= 1'b1;
        pos  <= '0;
        if (lfsr_step) lfsr <= lfsr_next;
      end else if (emit) begin
        if (is_end) begin
          busy <= 1'b0;
        end else begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  // Hold the segment payload
  always_ff @(posedge clk) begin
    if (seg_xfer) begin
      sx    <= seg.start_x;
      sy    <= seg.start_y;
      ex    <= seg.end_x;
      ey    <= seg.end_y;
      dx    <= DX_W'(seg.end_x) - DX_W'(seg.start_x);
      dy    <= DX_W'(seg.end_y) - DX_W'(seg.start_y);
      vflip <= vflip_next;
      hflip <= hflip_next;
      first <= seg.first_segment;
      cnt   <= cnt_next;
    end
  end

  srs_point_map u_map (
    .clk       (clk),
    .rst       (rst),
    .req_valid (busy),
    .req_ready (req_ready),
    .req       (req),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt)
  );

endmodule
`default_nettype wire

@@ rtl/core/srs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srs_checker: port-level checks for segment rule substitution
// Watches the top-level ports only; bound to the top level below.
// ---------------------------------------------------------------------------
module srs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          seg_valid,
  input logic                          seg_ready,
  input srs_pkg::seg_t                 seg,
  input logic                          pt_valid,
  input logic                          pt_ready,
  input srs_pkg::pt_t                  pt,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [srs_pkg::CFG_DATA_W-1:0] cfg_data
);

  // A stalled point holds valid and payload
  assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt_ready |=> pt_valid && $stable(pt))
    else $error("stalled point changed");

  // Reset empties the output register
  assert property (@(posedge clk) rst |=> !pt_valid)
    else $error("point valid after reset");

  // Reset leaves the sequencer free to take a segment
  assert property (@(posedge clk) rst |=> seg_ready)
    else $error("segment not accepted after reset");

  // A waiting segment holds valid and payload
  assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_ready |=> seg_valid && $stable(seg))
    else $error("waiting segment changed");

  // A waiting register write holds valid, index and data
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid && !cfg_ready |=> cfg_valid && $stable({cfg_index, cfg_data}))
    else $error("waiting register write changed");

endmodule

bind segment_rule_substitution srs_checker u_srs_checker (.*);
`default_nettype wire

@@ dv/segment_rule_substitution_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_rule_substitution_tb: self-checking bench for segment substitution
// Drives segments and rule settings through the valid/ready ports, predicts
// emitted points with an in-bench fixed-point mapper or from typed rows, and
// compares each transfer on the point channel field by field, in order.
// ---------------------------------------------------------------------------
module segment_rule_substitution_tb;
  import srs_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int TAIL_CYCLES     = 20;
  localparam int RANDOM_PHASES   = 9;
  localparam int SEGS_PER_PHASE  = 32;
  localparam int IDLE_PERCENT    = 7;

  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};

  // Flip codes outside the defined set behave as no flip
  localparam logic [2:0] FLIP_SPARE_LO  = 3'd5;
  localparam logic [2:0] FLIP_SPARE_MID = 3'd6;
  localparam logic [2:0] FLIP_SPARE_HI  = 3'd7;

  typedef struct {
    seg_t seg;
    bit   reprogram;
    int   n_typed;
    pt_t  typed0;
    pt_t  typed1;
  } seg_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  seg_valid = 1'b0;
  logic                  seg_ready;
  seg_t                  seg = '0;
  logic                  pt_valid;
  logic                  pt_ready = 1'b0;
  pt_t                   pt;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Bench copy of the block's settings and random-flip source
  logic [CNT_W-1:0]      rule_count_q = '0;
  logic [CFG_DATA_W-1:0] rule_pts_q [MAX_RULE_POINTS] = '{default: '0};
  logic [LFSR_W-1:0]     flip_lfsr_q = LFSR_SEED;

  pt_t      expected_pts [$];
  seg_row_t seg_rows [$];
  int       mismatch_count = 0;
  int       stall_cycles = 0;
  bit       quiet = 1'b0;
  bit       hold_off_go = 1'b0;
  bit       hold_off_done = 1'b0;

  segment_rule_substitution DUT (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock
  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > longint'(CMAX)) return CMAX;
    if (v < longint'(CMIN)) return CMIN;
    return COORD_W'(v);
  endfunction

  // Map the rule points onto one segment; advances the random-flip source in random mode
  function automatic void map_segment(input seg_t s, output pt_t pts[$]);
    longint x0, y0, x1, y1, dx, dy, rx, ry, px, py;
    bit     vflip, hflip;
    int     cnt, idx;
    logic   fb;
    x0 = longint'(s.start_x);
    y0 = longint'(s.start_y);
    x1 = longint'(s.end_x);
    y1 = longint'(s.end_y);
    dx = x1 - x0;
    dy = y1 - y0;
    vflip = 1'b0;
    hflip = 1'b0;
    cnt = int'(rule_count_q);
    if (cnt > MAX_RULE_POINTS) cnt = MAX_RULE_POINTS;
    pts = {};
    case (s.flip_mode)
      FLIP_V: vflip = 1'b1;
      FLIP_H: hflip = 1'b1;
      FLIP_BOTH: begin
        vflip = 1'b1;
        hflip = 1'b1;
      end
      FLIP_RAND: begin
        fb = flip_lfsr_q[0] ^ flip_lfsr_q[2] ^ flip_lfsr_q[3] ^ flip_lfsr_q[5];
        flip_lfsr_q = {fb, flip_lfsr_q[LFSR_W-1:1]};
        vflip = flip_lfsr_q[0];
      end
      default: ;
    endcase
    if (s.first_segment) pts.push_back(pt_t'{s.start_x, s.start_y, 1'b0});
    for (int k = 0; k < cnt; k++) begin
      idx = hflip ? (cnt - 1 - k) : k;
      rx = longint'($signed(rule_pts_q[idx][CFG_DATA_W-1:RULE_W]));
      ry = longint'($signed(rule_pts_q[idx][RULE_W-1:0]));
      if (vflip) ry = -ry;
      if (hflip) rx = ONE_Q14 - rx;
      // Round half up to Q16.16, then offset by the start point
      px = x0 + ((rx * dx - ry * dy + ONE_Q14 / 2) >>> FRAC_W);
      py = y0 + ((rx * dy + ry * dx + ONE_Q14 / 2) >>> FRAC_W);
      pts.push_back(pt_t'{clamp_coord(px), clamp_coord(py), 1'b0});
    end
    pts.push_back(pt_t'{s.end_x, s.end_y, 1'b1});
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one segment; queue its points at the transfer
  task automatic push_seg(input seg_t s, input int n_typed, input pt_t t0, input pt_t t1);
    pt_t pts [$];
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      seg_valid <= 1'b0;
      @(posedge clk);
    end
    seg_valid <= 1'b1;
    seg       <= s;
    do @(posedge clk); while (!seg_ready);
    map_segment(s, pts);
    if (n_typed > 0) begin
      if (n_typed > 1) expected_pts.push_back(t0);
      expected_pts.push_back(n_typed > 1 ? t1 : t0);
    end else begin
      foreach (pts[i]) expected_pts.push_back(pts[i]);
    end
  endtask

  // Write one register; leaves valid high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_RULE_COUNT) rule_count_q = data[CNT_W-1:0];
    else if (idx < NUM_REGS) rule_pts_q[idx - REG_RULE_POINT_0] = data;
  endtask

  // Wait until every queued point has been transferred
  task automatic drain();
    @(posedge clk);
    while (expected_pts.size() != 0) @(posedge clk);
  endtask

  // Load all rule points, poke an unmapped index, then set the count
  task automatic program_rules(input logic [CNT_W-1:0] count,
                               input logic [CFG_DATA_W-1:0] pts [MAX_RULE_POINTS]);
    for (int i = 0; i < MAX_RULE_POINTS; i++)
      write_reg(CFG_IDX_W'(REG_RULE_POINT_0 + i), pts[i]);
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)), $urandom);
    write_reg(CFG_IDX_W'(REG_RULE_COUNT), CFG_DATA_W'(count));
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(input longint sx, input longint sy, input longint ex,
                                  input longint ey, input logic [2:0] mode, input bit first,
                                  input bit reprog = 1'b0, input int n_typed = 0,
                                  input pt_t t0 = '0, input pt_t t1 = '0);
    seg_row_t r;
    r.seg = seg_t'{COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey), mode, first};
    r.reprogram = reprog;
    r.n_typed = n_typed;
    r.typed0 = t0;
    r.typed1 = t1;
    seg_rows.push_back(r);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3, 4: return $urandom;
      default: return $urandom_range(0, 2 ** 21) - 2 ** 20;
    endcase
  endfunction

  function automatic logic [RULE_W-1:0] rand_rule_half();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      default: return RULE_W'($urandom);
    endcase
  endfunction

  function automatic seg_t rand_seg();
    seg_t s;
    s.start_x = rand_coord();
    s.start_y = rand_coord();
    case ($urandom_range(0, 3))
      0: begin
        s.end_x = s.start_x;
        s.end_y = s.start_y;
      end
      1: begin
        s.end_x = s.start_x + ($urandom_range(0, 2 ** 17) - 2 ** 16);
        s.end_y = s.start_y + ($urandom_range(0, 2 ** 17) - 2 ** 16);
      end
      default: begin
        s.end_x = rand_coord();
        s.end_y = rand_coord();
      end
    endcase
    s.flip_mode = 3'($urandom_range(0, 7));
    s.first_segment = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Receiver: random stalls, plus one long hold-off to back up the pipe
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_off_done) begin
        pt_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        pt_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Check each point transfer and count cycles without any transfer
  always @(posedge clk) begin : point_monitor
    pt_t want;
    if (!rst) begin
      if (pt_valid && pt_ready) begin
        if (expected_pts.size() == 0) begin
          report_mismatch("unexpected point out_x", pt.out_x, 0);
        end else begin
          want = expected_pts.pop_front();
          if (pt.out_x !== want.out_x) report_mismatch("out_x", pt.out_x, want.out_x);
          if (pt.out_y !== want.out_y) report_mismatch("out_y", pt.out_y, want.out_y);
          if (pt.last_point !== want.last_point)
            report_mismatch("last_point", pt.last_point, want.last_point);
        end
      end
      if ((seg_valid && seg_ready) || (pt_valid && pt_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Abort when nothing moves for too long
  initial begin
    do @(posedge clk); while (stall_cycles < WATCHDOG_LIMIT);
    $display("segment_rule_substitution test failed");
    $finish;
  end

  // Stimulus
  initial begin
    logic [CFG_DATA_W-1:0] rules [MAX_RULE_POINTS];
    logic [CNT_W-1:0]      count;
    seg_row_t              r;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // After reset no rule points are in use: start and end pass straight through
    add_row(CMIN, CMIN, CMAX, CMAX, FLIP_NONE, 1'b1, 1'b0, 2,
            pt_t'{CMIN, CMIN, 1'b0}, pt_t'{CMAX, CMAX, 1'b1});
    add_row(CMAX, CMAX, CMIN, CMIN, FLIP_BOTH, 1'b0, 1'b0, 1, pt_t'{CMIN, CMIN, 1'b1});
    add_row(0, 0, 0, 0, FLIP_RAND, 1'b1, 1'b0, 2, pt_t'{0, 0, 1'b0}, pt_t'{0, 0, 1'b1});
    add_row(-1, 1, 1, -1, FLIP_SPARE_HI, 1'b1, 1'b0, 2,
            pt_t'{-1, 1, 1'b0}, pt_t'{1, -1, 1'b1});
    add_row(32'h1234_5678, -32'h00AB_CDEF, 32'h7654_3210, 32'h0F0F_0F0F, FLIP_H, 1'b0,
            1'b0, 1, pt_t'{32'h7654_3210, 32'h0F0F_0F0F, 1'b1});
    // Full rule set with extreme points; every flip code
    add_row(0, 0, 32'h0001_0000, 0, FLIP_NONE, 1'b1, 1'b1);
    add_row(0, 0, 32'h0001_0000, 0, FLIP_V, 1'b0);
    add_row(32'h0002_0000, -32'h0003_0000, 32'h0005_8000, 32'h0001_0000, FLIP_H, 1'b1);
    add_row(-32'h0010_0000, 32'h0000_4000, 32'h0020_0000, -32'h0007_0000, FLIP_BOTH, 1'b0);
    add_row(0, 0, 32'h0001_0000, 32'h0001_0000, FLIP_RAND, 1'b1);
    add_row(32'h0000_1000, 0, -32'h0000_1000, 32'h0003_0000, FLIP_SPARE_LO, 1'b0);
    add_row(32'h0100_0000, 32'h0100_0000, 0, 0, FLIP_SPARE_MID, 1'b1);
    add_row(0, 32'h0004_0000, 32'h0004_0000, 0, FLIP_SPARE_HI, 1'b0);
    // Saturation, zero length, rounding of tiny deltas, repeated random flips
    add_row(CMIN, CMIN, CMAX, CMAX, FLIP_H, 1'b1);
    add_row(CMAX, 0, CMIN, 0, FLIP_V, 1'b0);
    add_row(CMAX, CMIN, CMIN, CMAX, FLIP_RAND, 1'b1);
    add_row(32'h1234_0000, -32'h0001_0000, 32'h1234_0000, -32'h0001_0000, FLIP_RAND, 1'b1);
    add_row(0, 0, 1, 0, FLIP_NONE, 1'b0);
    add_row(0, 0, -1, 3, FLIP_BOTH, 1'b1);
    add_row(5, -7, 2, 9, FLIP_RAND, 1'b0);

    rules = '{32'h4000_0000, 32'h0000_4000, 32'h8000_7FFF, 32'h7FFF_8000,
              32'h2000_E000, 32'h0000_0000, 32'hFFFF_0001};
    foreach (seg_rows[i]) begin
      r = seg_rows[i];
      if (r.reprogram) begin
        seg_valid <= 1'b0;
        drain();
        program_rules(CNT_W'(MAX_RULE_POINTS), rules);
      end
      push_seg(r.seg, r.n_typed, r.typed0, r.typed1);
    end

    // Random phases, each with its own rule setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      seg_valid <= 1'b0;
      drain();
      foreach (rules[i]) rules[i] = {rand_rule_half(), rand_rule_half()};
      case (ph)
        0: count = '0;
        1: count = CNT_W'(MAX_RULE_POINTS);
        2: count = CNT_W'(1);
        default: count = CNT_W'($urandom_range(0, MAX_RULE_POINTS));
      endcase
      program_rules(count, rules);
      quiet = (ph == 3) || (ph == 4);
      if (ph == 1) hold_off_go = 1'b1;
      repeat (SEGS_PER_PHASE) push_seg(rand_seg(), 0, '0, '0);
    end

    // Let the pipe empty, then watch for stray points
    seg_valid <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("segment_rule_substitution test passed");
    end else begin
      $display("segment_rule_substitution test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/srs_pkg.sv
rtl/core/srs_point_map.sv
rtl/core/segment_rule_substitution.sv
rtl/core/srs_checker.sv
dv/segment_rule_substitution_tb.sv
